### rtl/jst_pkg.sv
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and constants for the jittered spawn timer bank.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int ENTRIES = 64;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [31:0] RNG_FIRST_INIT  = 32'h3E50B28C;
  localparam logic [31:0] RNG_SECOND_INIT = 32'hD461A7F9;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_INIT  = 2'd1;
  localparam logic [1:0] REQ_SPAWN = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         entry_index;
    logic [14:0]        head_position;
    logic signed [15:0] tail_offset;
    logic signed [15:0] step_now;
    logic [14:0]        jitter_mask;
    logic [14:0]        base_delay;
    logic               force_all;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  fired_index;
    logic [11:0] head_byte;
    logic [2:0]  head_bit;
    logic [11:0] tail_byte;
    logic [2:0]  tail_bit;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_INIT,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic init_wr;
    logic eval_step;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic idx_last;
    logic fire;
    logic fire_ok;
    logic pend_valid;
    logic out_free;
  } ctrl_sts_t;

endpackage

### rtl/jst_req_if.sv
// ----------------------------------------------------------------------------
// jst_req_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface jst_req_if import jst_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/jst_rsp_if.sv
// ----------------------------------------------------------------------------
// jst_rsp_if
// Valid/ready channel carrying one fired-entry result.
// ----------------------------------------------------------------------------
interface jst_rsp_if import jst_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/jst_ram.sv
// ----------------------------------------------------------------------------
// jst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/jst_ctrl.sv
// ----------------------------------------------------------------------------
// jst_ctrl
// Sequencer for load, schedule and spawn passes over the entry bank.
// ----------------------------------------------------------------------------
module jst_ctrl import jst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_type,
  output logic       req_ready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_type)
            REQ_LOAD:  state_next = ST_LOAD;
            REQ_INIT:  state_next = sts.n_zero ? ST_IDLE : ST_INIT;
            REQ_SPAWN: state_next = sts.n_zero ? ST_IDLE : ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_next = ST_IDLE;
      ST_INIT: begin
        if (sts.idx_last) state_next = ST_IDLE;
      end
      ST_READ:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (!sts.fire || sts.fire_ok) begin
          state_next = sts.idx_last ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = (state == ST_IDLE);
    cmd           = '0;
    cmd.capture   = (state == ST_IDLE) && req_valid;
    cmd.load_wr   = (state == ST_LOAD);
    cmd.init_wr   = (state == ST_INIT);
    cmd.eval_step = (state == ST_EVAL) && (!sts.fire || sts.fire_ok);
    cmd.flush     = (state == ST_FLUSH) && sts.pend_valid && sts.out_free;
  end

endmodule

### rtl/jst_dp.sv
// ----------------------------------------------------------------------------
// jst_dp
// Entry stores, generator, deadline update and result staging.
// ----------------------------------------------------------------------------
module jst_dp import jst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  in_item_t   req_data,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output out_item_t  rsp_data
);

  logic [6:0]  num_entries;
  logic [6:0]  n_act;
  in_item_t    req_q;
  logic [5:0]  idx;
  logic [31:0] rng_first;
  logic [31:0] rng_second;
  logic        rng_step;
  logic [15:0] jitter;
  logic [15:0] dl_wdata;
  logic [15:0] dl_rdata;
  logic        dl_we;
  logic [30:0] ho_rdata;
  logic        ho_we;
  logic [14:0] head;
  logic [14:0] tail;
  logic        fire;
  logic        out_free;
  logic        pend_valid;
  out_item_t   pend;
  out_item_t   pend_out;
  out_item_t   fired;
  logic        move;

  assign n_act = (num_entries > 7'(ENTRIES)) ? 7'(ENTRIES) : num_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries <= '0;
    end else if (cfg_we) begin
      num_entries <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.init_wr || cmd.eval_step) begin
      idx <= idx + 6'd1;
    end
  end

  // add-swap generator, one step per scheduled entry
  assign rng_step = cmd.init_wr || (cmd.eval_step && fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_first  <= RNG_FIRST_INIT;
      rng_second <= RNG_SECOND_INIT;
    end else if (rng_step) begin
      rng_first  <= rng_first + {rng_second[15:0], rng_second[31:16]};
      rng_second <= rng_second + rng_first;
    end
  end

  assign jitter   = 16'(rng_first[14:0] & req_q.jitter_mask) + 16'(req_q.base_delay);
  assign dl_wdata = cmd.init_wr ? (req_q.step_now + jitter) : (dl_rdata + jitter);
  assign dl_we    = rng_step;
  assign ho_we    = cmd.load_wr && (7'(req_q.entry_index) < 7'(ENTRIES));

  jst_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_deadline (
    .clk   (clk),
    .we    (dl_we),
    .waddr (idx[ADDR_W-1:0]),
    .wdata (dl_wdata),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (dl_rdata)
  );

  jst_ram #(.WIDTH(31), .DEPTH(ENTRIES)) u_head_offset (
    .clk   (clk),
    .we    (ho_we),
    .waddr (req_q.entry_index[ADDR_W-1:0]),
    .wdata ({req_q.head_position, req_q.tail_offset}),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ho_rdata)
  );

  assign head = ho_rdata[30:16];
  assign tail = head + ho_rdata[14:0];
  assign fire = req_q.force_all || ($signed(dl_rdata) <= req_q.step_now);

  always_comb begin
    fired             = '0;
    fired.fired_index = idx;
    fired.head_byte   = head[14:3];
    fired.head_bit    = ~head[2:0];
    fired.tail_byte   = tail[14:3];
    fired.tail_bit    = ~tail[2:0];
  end

  // one fired entry is held back until the next one or the pass end decides last
  assign out_free = !rsp_valid || rsp_ready;
  assign move     = (cmd.eval_step && fire && pend_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.eval_step && fire) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_step && fire) begin
      pend <= fired;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    pend_out      = pend;
    pend_out.last = cmd.flush;
  end

  always_ff @(posedge clk) begin
    if (move) begin
      rsp_data <= pend_out;
    end
  end

  always_comb begin
    sts            = '0;
    sts.n_zero     = (n_act == 7'd0);
    sts.idx_last   = ({1'b0, idx} == (n_act - 7'd1));
    sts.fire       = fire;
    sts.fire_ok    = !pend_valid || out_free;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

endmodule

### rtl/jittered_spawn_timer_bank.sv
// ----------------------------------------------------------------------------
// jittered_spawn_timer_bank
// Bank of jittered deadlines: load, schedule and spawn passes over the entries.
// ----------------------------------------------------------------------------
// Schedule request: one entry per cycle over n entries. Spawn request: each
// entry passes through a RAM read state and an evaluate state, and output
// stalls hold the evaluate state; the deadline RAM reads and writes at the entry index.
// Results leave through a held-back stage and an output register, so the last
// result appears after the pass ends. n = min(num_entries, 64).
// Reset clears the generator and num_entries; entry stores are not cleared.
module jittered_spawn_timer_bank import jst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  jst_req_if.sink    req,
  jst_rsp_if.source  rsp
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  jst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.data.req_type),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_data  (req.data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule
